// ===== src/ptt_pkg.sv =====
// Shared constants, codes and control types for the periodic task timer table.
// No dependencies; imported by every module of the block.
package ptt_pkg;

  // Table size and tick length.
  localparam int NUM_SLOTS = 16;
  localparam int TICK_MS   = 10;

  // Slot index width (at least one bit).
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Field widths.
  localparam int KIND_W   = 2;
  localparam int MS_W     = 32;
  localparam int TASK_W   = 4;
  localparam int MASK_W   = 16;
  localparam int STATUS_W = 2;

  // Fire vector wide enough for both the table and the mask port.
  localparam int FIRE_W = (NUM_SLOTS > MASK_W) ? NUM_SLOTS : MASK_W;

  // Divide by TICK_MS: multiply by a rounded-up reciprocal, then shift.
  // Exact for every MS_W-bit dividend since MAGIC*TICK_MS exceeds 2^(MS_W+SHIFT)
  // by at most 2^SHIFT.
  localparam int DIV_SHIFT = $clog2(TICK_MS);
  localparam logic [MS_W:0] DIV_MAGIC =
    (MS_W+1)'(((64'd1 << (MS_W + DIV_SHIFT)) / TICK_MS) + 64'd1);

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEL  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture the input item
    logic div_step;  // ms-to-tick conversion of the captured times
    logic exec;      // apply the item to the table and load the result
  } ptt_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic in_is_add; // offered item is an add
    logic out_free;  // result register can take a new result this cycle
  } ptt_stat_t;

endpackage

// ===== src/ptt_ctrl.sv =====
// Sequencer for the periodic task timer table: accept, divide (adds only), execute.
// Depends on ptt_pkg.
module ptt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ptt_pkg::ptt_stat_t  stat_i,
  output ptt_pkg::ptt_cmd_t   cmd_o
);
  import ptt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.in_is_add ? S_DIV : S_EXEC;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d        = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  // The divide state always goes straight on to execute.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |=> (state_q == S_EXEC))
    else $error("divider did not hand over to execute");
`endif

endmodule

// ===== src/ptt_datapath.sv =====
// Slot table, ms-to-tick divider and result register of the task timer table.
// Depends on ptt_pkg.
module ptt_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ptt_pkg::ptt_cmd_t          cmd_i,
  output ptt_pkg::ptt_stat_t         stat_o,
  input  logic [ptt_pkg::KIND_W-1:0] kind_i,
  input  logic [ptt_pkg::MS_W-1:0]   delay_ms_i,
  input  logic [ptt_pkg::MS_W-1:0]   period_ms_i,
  input  logic [ptt_pkg::TASK_W-1:0] task_id_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic [ptt_pkg::MASK_W-1:0] ready_mask_o,
  output logic [ptt_pkg::TASK_W-1:0] slot_o,
  output logic [ptt_pkg::STATUS_W-1:0] status_o
);
  import ptt_pkg::*;

  // Captured item.
  logic [KIND_W-1:0] kind_q;
  logic [TASK_W-1:0] task_id_q;

  // Captured times; replaced by their tick counts on the divide step.
  logic [MS_W-1:0]   dly_q, per_q;
  logic [2*MS_W:0]   dly_prod, per_prod;

  // Slot table.
  logic [MS_W-1:0]      cnt_q [NUM_SLOTS];
  logic [MS_W-1:0]      cnt_d [NUM_SLOTS];
  logic [MS_W-1:0]      rel_q [NUM_SLOTS];
  logic [MS_W-1:0]      rel_d [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] used_q, used_d;
  logic [FIRE_W-1:0]    fire;

  logic              any_free;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] del_idx;
  logic              del_ok;

  logic [TASK_W-1:0]   slot_res;
  logic [STATUS_W-1:0] status_res;

  // Result register.
  logic                out_valid_q;
  logic [MASK_W-1:0]   mask_q;
  logic [TASK_W-1:0]   slot_q;
  logic [STATUS_W-1:0] status_q;

  assign stat_o.in_is_add = (kind_i == KIND_ADD);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  // Reciprocal multiply for the division by TICK_MS.
  assign dly_prod = (2*MS_W+1)'(dly_q) * (2*MS_W+1)'(DIV_MAGIC);
  assign per_prod = (2*MS_W+1)'(per_q) * (2*MS_W+1)'(DIV_MAGIC);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q    <= kind_i;
      task_id_q <= task_id_i;
      dly_q     <= delay_ms_i;
      per_q     <= period_ms_i;
    end else if (cmd_i.div_step) begin
      dly_q <= MS_W'(dly_prod >> (MS_W + DIV_SHIFT));
      per_q <= MS_W'(per_prod >> (MS_W + DIV_SHIFT));
    end
  end

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end
  assign any_free = !(&used_q);

  assign del_idx = SLOT_W'(task_id_q);
  assign del_ok  = (int'(task_id_q) < NUM_SLOTS) && used_q[del_idx];

  // Per-slot next state; all slots update in parallel on a tick.
  always_comb begin
    fire   = '0;
    used_d = used_q;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      cnt_d[i] = cnt_q[i];
      rel_d[i] = rel_q[i];
      if (cmd_i.exec) begin
        case (kind_q)
          KIND_TICK: begin
            if (used_q[i]) begin
              if (cnt_q[i] == '0) begin
                fire[i] = 1'b1;
                if (rel_q[i] == '0) begin
                  used_d[i] = 1'b0;   // one-shot done, counters already zero
                end else begin
                  cnt_d[i] = rel_q[i] - 1'b1;
                end
              end else begin
                cnt_d[i] = cnt_q[i] - 1'b1;
              end
            end
          end
          KIND_ADD: begin
            if (any_free && free_idx == SLOT_W'(i)) begin
              used_d[i] = 1'b1;
              cnt_d[i]  = dly_q;
              rel_d[i]  = per_q;
            end
          end
          KIND_DEL: begin
            if (del_ok && del_idx == SLOT_W'(i)) begin
              used_d[i] = 1'b0;
              cnt_d[i]  = '0;
              rel_d[i]  = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    slot_res   = '0;
    status_res = STATUS_OK;
    case (kind_q)
      KIND_ADD: begin
        if (any_free) begin
          slot_res = TASK_W'(free_idx);
        end else begin
          status_res = STATUS_FULL;
        end
      end
      KIND_DEL: begin
        if (!del_ok) begin
          status_res = STATUS_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        cnt_q[i] <= '0;
        rel_q[i] <= '0;
      end
    end else begin
      used_q <= used_d;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        cnt_q[i] <= cnt_d[i];
        rel_q[i] <= rel_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      mask_q   <= fire[MASK_W-1:0];
      slot_q   <= slot_res;
      status_q <= status_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ready_mask_o = mask_q;
  assign slot_o       = slot_q;
  assign status_o     = status_q;

`ifndef SYNTHESIS
  // A result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten");

  // Loading, dividing and executing are mutually exclusive.
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.load, cmd_i.div_step, cmd_i.exec}))
    else $error("conflicting datapath commands");

  // A fire mask only comes with an ok status and slot zero.
  a_mask_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && mask_q != '0) |-> (status_q == STATUS_OK && slot_q == '0))
    else $error("fire mask on a non-tick result");
`endif

endmodule

// ===== src/periodic_task_timer_table.sv =====
// Top level of the periodic task timer table.
// Depends on ptt_pkg, ptt_ctrl and ptt_datapath.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item: a tick, an add
//   (delay_ms_i, period_ms_i) or a delete (task_id_i). Output channel
//   (out_valid_o / out_stall_i) returns exactly one result per item:
//   ready_mask_o for a tick, slot_o and status_o for add and delete.
//   A transfer happens on a rising edge with valid high and stall low.
// Sequence:
//   Tick, delete and unknown kinds: the item is captured, then applied in
//   the execute state once the result register is free to take its result.
//   Add: a divide state between capture and execute does the ms-to-tick
//   conversion (a multiply by the reciprocal of TICK_MS), then the add is
//   applied in the execute state as above.
//   One item is in work at a time; in_stall_o is high until it has executed.
// Output stall: results sit in a register; the next item is taken while a
//   result waits, and it executes only once that register has been drained.
// Reset: all slots free, no result pending, ready for input right away.
module periodic_task_timer_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ptt_pkg::KIND_W-1:0]   kind_i,
  input  logic [ptt_pkg::MS_W-1:0]     delay_ms_i,
  input  logic [ptt_pkg::MS_W-1:0]     period_ms_i,
  input  logic [ptt_pkg::TASK_W-1:0]   task_id_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ptt_pkg::MASK_W-1:0]   ready_mask_o,
  output logic [ptt_pkg::TASK_W-1:0]   slot_o,
  output logic [ptt_pkg::STATUS_W-1:0] status_o
);
  import ptt_pkg::*;

  ptt_cmd_t  cmd;
  ptt_stat_t stat;

  // Sequencer: decides when to capture, divide and commit.
  ptt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Slot counters, divider and result register.
  ptt_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .kind_i       (kind_i),
    .delay_ms_i   (delay_ms_i),
    .period_ms_i  (period_ms_i),
    .task_id_i    (task_id_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .ready_mask_o (ready_mask_o),
    .slot_o       (slot_o),
    .status_o     (status_o)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for periodic_task_timer_table: a directed table, then random add, delete
// and tick traffic with random idling on both channels, checked against an in-bench table model.
// Depends on ptt_pkg and the periodic_task_timer_table RTL only.
module tb;
  import ptt_pkg::*;

  // Kind code that the block ignores; the package names only the three real kinds.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [MS_W-1:0]   TICK_DIV    = TICK_MS;
  // Longest quiet stretch a correct run can show is the receiver jam below plus one add.
  localparam int JAM_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [MS_W-1:0]   delay_ms;
    logic [MS_W-1:0]   period_ms;
    logic [TASK_W-1:0] task_id;
  } job_t;

  typedef struct packed {
    logic [MASK_W-1:0]   mask;
    logic [TASK_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
  } reply_t;

  // One line of the directed table; typed rows carry a hand-written answer.
  typedef struct packed {
    job_t   job;
    bit     typed;
    reply_t want;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [KIND_W-1:0]   kind_i;
  logic [MS_W-1:0]     delay_ms_i;
  logic [MS_W-1:0]     period_ms_i;
  logic [TASK_W-1:0]   task_id_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [MASK_W-1:0]   ready_mask_o;
  logic [TASK_W-1:0]   slot_o;
  logic [STATUS_W-1:0] status_o;

  periodic_task_timer_table uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .delay_ms_i   (delay_ms_i),
    .period_ms_i  (period_ms_i),
    .task_id_i    (task_id_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ready_mask_o (ready_mask_o),
    .slot_o       (slot_o),
    .status_o     (status_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Table model: mirrors the slot counters of the block.
  logic [MS_W-1:0] count_left [NUM_SLOTS];
  logic [MS_W-1:0] reload_len [NUM_SLOTS];
  bit              in_use     [NUM_SLOTS];

  reply_t    pending_replies[$];
  plan_row_t plan[$];
  int        errors = 0;
  int        idle_cycles = 0;
  bit        calm = 1'b0;     // no idling on either side while set
  bit        jam_req = 1'b0;  // ask the receiver for one long hold-off

  function automatic void release_slot(int s);
    in_use[s]     = 1'b0;
    count_left[s] = '0;
    reload_len[s] = '0;
  endfunction

  // Applies one transfer to the table model and returns the result it must produce.
  function automatic reply_t advance_table(job_t j);
    reply_t r;
    bit     placed;
    r = '0;
    placed = 1'b0;
    case (j.kind)
      KIND_TICK: begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (in_use[s]) begin
            if (count_left[s] == '0) begin
              if (s < MASK_W) r.mask[s] = 1'b1;
              // zero period means one-shot: the slot is freed once it fires
              if (reload_len[s] == '0) release_slot(s);
              else count_left[s] = reload_len[s] - 1;
            end else begin
              count_left[s] = count_left[s] - 1;
            end
          end
        end
      end
      KIND_ADD: begin
        r.status = STATUS_FULL;
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (!placed && !in_use[s]) begin
            placed        = 1'b1;
            in_use[s]     = 1'b1;
            count_left[s] = j.delay_ms / TICK_DIV;
            reload_len[s] = j.period_ms / TICK_DIV;
            r.slot        = s[TASK_W-1:0];
            r.status      = STATUS_OK;
          end
        end
      end
      KIND_DEL: begin
        if (int'(j.task_id) < NUM_SLOTS && in_use[j.task_id]) begin
          release_slot(j.task_id);
          r.status = STATUS_OK;
        end else begin
          r.status = STATUS_NOT_FOUND;
        end
      end
      default: ;  // unknown kind: all-zero result, table untouched
    endcase
    return r;
  endfunction

  function automatic void plan_job(logic [KIND_W-1:0] kind, logic [MS_W-1:0] delay_ms,
                                   logic [MS_W-1:0] period_ms, logic [TASK_W-1:0] task_id,
                                   bit typed, logic [MASK_W-1:0] mask,
                                   logic [TASK_W-1:0] slot, logic [STATUS_W-1:0] status);
    plan_row_t row;
    row.job   = '{kind, delay_ms, period_ms, task_id};
    row.typed = typed;
    row.want  = '{mask, slot, status};
    plan.push_back(row);
  endfunction

  // Mostly short times so slots fire often; some one-shots and some full-range values.
  function automatic logic [MS_W-1:0] draw_ms(int one_shot_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < one_shot_pct) return $urandom_range(0, TICK_MS - 1);
    if (r < 75) return $urandom_range(TICK_MS, 8 * TICK_MS);
    if (r < 92) return $urandom_range(0, 60 * TICK_MS);
    return $urandom();
  endfunction

  // Sender: optional gap, then hold the item until the block takes it. Ends at a falling
  // edge with valid still high, so a back-to-back item never drops valid in between.
  task automatic send_job(input job_t j, input bit typed, input reply_t want);
    int     gap;
    reply_t predicted;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i      = j.kind;
    delay_ms_i  = j.delay_ms;
    period_ms_i = j.period_ms;
    task_id_i   = j.task_id;
    in_valid_i  = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = advance_table(j);
    pending_replies.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  // Sender pause: nothing offered until every result is back.
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
  endtask

  // Random traffic; adds and deletes by percentage, the rest ticks plus a little noise.
  // Ignored kinds are not counted toward the item count.
  task automatic random_phase(input int items, input int add_pct, input int del_pct);
    int   sent;
    int   r;
    int   live[$];
    job_t j;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(0, 99);
      j = '0;
      j.delay_ms  = $urandom();
      j.period_ms = $urandom();
      j.task_id   = TASK_W'($urandom_range(0, 15));
      if (r < add_pct) begin
        j.kind      = KIND_ADD;
        j.delay_ms  = draw_ms(20);
        j.period_ms = draw_ms(25);
      end else if (r < add_pct + del_pct) begin
        j.kind = KIND_DEL;
        live.delete();
        for (int s = 0; s < NUM_SLOTS; s++) if (in_use[s]) live.push_back(s);
        // mostly hit a live slot; otherwise any id, which may be free
        if (live.size() != 0 && $urandom_range(0, 9) < 8)
          j.task_id = TASK_W'(live[$urandom_range(0, live.size() - 1)]);
      end else if (r < add_pct + del_pct + 3) begin
        j.kind = KIND_UNUSED;
      end else begin
        j.kind = KIND_TICK;
      end
      send_job(j, 1'b0, '0);
      if (j.kind != KIND_UNUSED) sent++;
    end
  endtask

  // Receiver: each result waits a drawn number of cycles while valid; a jam request
  // holds stall high for a long stretch counted here, whatever the sender does.
  initial begin
    int     hold;
    int     jam_left;
    reply_t want;
    hold        = 0;
    jam_left    = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (jam_req) begin
        jam_left = JAM_CYCLES;
        jam_req  = 1'b0;
      end
      out_stall_i = (hold > 0) || (jam_left > 0);
      @(posedge clk_i);
      if (jam_left > 0) jam_left--;
      if (out_valid_o) begin
        if (!out_stall_i) begin
          if (pending_replies.size() == 0) begin
            $display("%0t: result with none pending: mask %h slot %0d status %0d",
                     $time, ready_mask_o, slot_o, status_o);
            errors++;
          end else begin
            want = pending_replies.pop_front();
            if (ready_mask_o !== want.mask) begin
              $display("%0t: ready_mask expected %h got %h", $time, want.mask, ready_mask_o);
              errors++;
            end
            if (slot_o !== want.slot) begin
              $display("%0t: slot expected %0d got %0d", $time, want.slot, slot_o);
              errors++;
            end
            if (status_o !== want.status) begin
              $display("%0t: status expected %0d got %0d", $time, want.status, status_o);
              errors++;
            end
          end
          hold = calm ? 0 : $urandom_range(0, 6);
        end else if (hold > 0) begin
          hold--;
        end
      end
    end
  end

  // Watchdog: a run that moves nothing on either channel for too long is hung.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t row;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    kind_i      = KIND_TICK;
    delay_ms_i  = '0;
    period_ms_i = '0;
    task_id_i   = '0;
    for (int s = 0; s < NUM_SLOTS; s++) release_slot(s);

    // Directed table. Typed answers where they are plain; the rest go through the model.
    plan_job(KIND_TICK, '0, '0, '0, 1'b1, '0, '0, STATUS_OK);               // tick on empty table
    plan_job(KIND_UNUSED, '1, '1, 4'd15, 1'b1, '0, '0, STATUS_OK);          // ignored kind
    plan_job(KIND_DEL, '1, '1, 4'd15, 1'b1, '0, '0, STATUS_NOT_FOUND);      // delete of free slot
    plan_job(KIND_ADD, '0, '0, '0, 1'b1, '0, 4'd0, STATUS_OK);              // one-shot, fires on the next tick
    plan_job(KIND_TICK, '0, '0, '0, 1'b1, 16'h0001, '0, STATUS_OK);         // fires, slot freed
    plan_job(KIND_ADD, '1, '1, '0, 1'b1, '0, 4'd0, STATUS_OK);              // freed slot reused
    plan_job(KIND_ADD, 32'd9, 32'd10, '0, 1'b1, '0, 4'd1, STATUS_OK);       // 0 ticks, period 1
    plan_job(KIND_ADD, 32'd19, 32'd29, '0, 1'b1, '0, 4'd2, STATUS_OK);      // 1 tick, period 2
    plan_job(KIND_TICK, '0, '0, '0, 1'b0, '0, '0, STATUS_OK);
    plan_job(KIND_TICK, '0, '0, '0, 1'b0, '0, '0, STATUS_OK);
    plan_job(KIND_DEL, '0, '0, 4'd0, 1'b1, '0, '0, STATUS_OK);              // delete of the head
    plan_job(KIND_DEL, '0, '0, 4'd0, 1'b1, '0, '0, STATUS_NOT_FOUND);       // and again
    // Fill every free slot, then one add too many.
    for (int k = 0; k < NUM_SLOTS - 2; k++)
      plan_job(KIND_ADD, $urandom_range(0, 400), $urandom_range(0, 400), '0, 1'b0, '0, '0,
               STATUS_OK);
    plan_job(KIND_ADD, 32'd50, 32'd50, '0, 1'b1, '0, '0, STATUS_FULL);      // table full

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      row = plan[i];
      send_job(row.job, row.typed, row.want);
    end
    drain_results();

    random_phase(120, 25, 15);
    drain_results();

    // Receiver jams while the sender keeps offering: the block must back up and stall.
    jam_req = 1'b1;
    random_phase(60, 20, 10);
    drain_results();

    // Stretch with no idling at all.
    calm = 1'b1;
    random_phase(100, 30, 15);
    calm = 1'b0;
    drain_results();

    random_phase(150, 60, 10);  // add heavy: runs into table full
    drain_results();
    random_phase(150, 15, 30);  // delete heavy
    drain_results();
    random_phase(150, 35, 20);
    drain_results();
    random_phase(100, 10, 5);   // tick heavy: many fires and reloads
    drain_results();
    random_phase(100, 45, 25);
    drain_results();

    // Let any stray result show up before judging.
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
